FILE: hw/rtl/pxu_pkg.sv
package pxu_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BYTES_PER_PIXEL = 3'd0,
    REG_INDEXED_MODE    = 3'd1,
    REG_RED_MASK        = 3'd2,
    REG_GREEN_MASK      = 3'd3,
    REG_BLUE_MASK       = 3'd4
  } reg_index_t;

  // Input item kinds carried on tuser
  localparam logic CMD_CONVERT       = 1'b0;
  localparam logic CMD_PALETTE_WRITE = 1'b1;

  // Live configuration plus the per-channel right shift derived from each mask
  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        indexed_mode;
    logic [31:0] red_mask;
    logic [31:0] green_mask;
    logic [31:0] blue_mask;
    logic [4:0]  red_shift;
    logic [4:0]  green_shift;
    logic [4:0]  blue_shift;
  } cfg_t;

endpackage

FILE: hw/rtl/pixel_unpack_to_argb8888_unit.sv
// Pixel unpacker: turns one source pixel per request into an opaque ARGB8888
// word. A convert request keeps the low bytes_per_pixel bytes of pixel_word;
// in indexed mode a pixel below PALETTE_ENTRIES looks up the RGB palette,
// otherwise each channel is the pixel ANDed with its mask and shifted down to
// the mask's lowest set bit. Alpha is always 0xFF. A palette-write request
// stores one entry and returns nothing. The unit accepts one request every
// clock while the output is not stalled. A convert result passes two
// registers: stage 1, beside the palette RAM read register, loads at the
// accepting edge, and the output register then loads from stage 1. Output
// back-pressure holds both stages. The palette reads as all zero right after
// reset through one valid flop per entry, so there is no clearing pass. Write
// configuration only while no request is in flight.
module pixel_unpack_to_argb8888_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // pixel_word[31:0], palette_index[39:32], entry_red[47:40],
  // entry_green[55:48], entry_blue[63:56]
  input  logic [63:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // argb_pixel[31:0]
  output logic [31:0] m_tdata
);

  import pxu_pkg::*;

  localparam int AW = $clog2(PALETTE_ENTRIES);

  cfg_t cfg;

  pxu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Request fields
  logic [31:0] pixel_word;
  logic [7:0]  palette_index;
  logic [23:0] entry_rgb;

  assign pixel_word    = s_tdata[31:0];
  assign palette_index = s_tdata[39:32];
  assign entry_rgb     = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};

  // Handshake: stage 1 advances when empty or when the output can take it
  logic s1_valid;
  logic out_free;
  logic s1_adv;
  logic accept;
  logic take_convert;

  assign out_free     = !m_tvalid || m_tready;
  assign s1_adv       = !s1_valid || out_free;
  assign s_tready     = s1_adv;
  assign accept       = s_tvalid && s_tready;
  assign take_convert = accept && (s_tuser == CMD_CONVERT);

  // Keep only the configured number of low bytes
  logic [31:0] src_pixel;

  always_comb begin
    unique case (cfg.bytes_per_pixel)
      3'd0:    src_pixel = '0;
      3'd1:    src_pixel = {24'd0, pixel_word[7:0]};
      3'd2:    src_pixel = {16'd0, pixel_word[15:0]};
      3'd3:    src_pixel = {8'd0, pixel_word[23:0]};
      default: src_pixel = pixel_word;
    endcase
  end

  logic pix_in_table;
  logic wr_in_table;
  logic pal_we;
  logic pal_re;

  assign pix_in_table = src_pixel < 32'(PALETTE_ENTRIES);
  assign wr_in_table  = 32'(palette_index) < 32'(PALETTE_ENTRIES);
  assign pal_we       = accept && (s_tuser == CMD_PALETTE_WRITE) && wr_in_table;
  assign pal_re       = take_convert && cfg.indexed_mode && pix_in_table;

  // Palette storage; write and read both happen at the accepting edge, so a
  // convert right after a write to the same entry sees the new value.
  logic [23:0] pal_rdata;

  pxu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[AW-1:0]),
    .wdata (entry_rgb),
    .re    (pal_re),
    .raddr (src_pixel[AW-1:0]),
    .rdata (pal_rdata)
  );

  // One valid flop per entry; an unwritten entry reads as zero
  logic [PALETTE_ENTRIES-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (pal_we) begin
      entry_valid[palette_index[AW-1:0]] <= 1'b1;
    end
  end

  // Stage 1: source pixel and lookup decision, beside the RAM read register
  logic [31:0] s1_pixel;
  logic        s1_use_pal;
  logic        s1_ent_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= take_convert;
    end
  end

  always_ff @(posedge clk) begin
    if (take_convert) begin
      s1_pixel     <= src_pixel;
      s1_use_pal   <= cfg.indexed_mode && pix_in_table;
      s1_ent_valid <= entry_valid[src_pixel[AW-1:0]];
    end
  end

  // Channel extraction: mask, then shift the field down to bit 0
  logic [31:0] red_field;
  logic [31:0] green_field;
  logic [31:0] blue_field;
  logic [23:0] rgb;

  assign red_field   = (s1_pixel & cfg.red_mask) >> cfg.red_shift;
  assign green_field = (s1_pixel & cfg.green_mask) >> cfg.green_shift;
  assign blue_field  = (s1_pixel & cfg.blue_mask) >> cfg.blue_shift;

  always_comb begin
    if (s1_use_pal) begin
      rgb = s1_ent_valid ? pal_rdata : 24'd0;
    end else begin
      rgb = {red_field[7:0], green_field[7:0], blue_field[7:0]};
    end
  end

  // Output register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      m_tdata <= {8'hFF, rgb};
    end
  end

endmodule

FILE: hw/rtl/pxu_ram.sv
module pxu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/pxu_cfg.sv
module pxu_cfg (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output pxu_pkg::cfg_t cfg
);

  import pxu_pkg::*;

  // Position of the lowest set bit; a zero mask gives 0
  function automatic logic [4:0] trailing_zeros(input logic [31:0] m);
    logic [4:0] n;
    n = '0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

  logic [4:0] data_shift;

  assign cfg_ready  = 1'b1;
  assign data_shift = trailing_zeros(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= 3'd4;
      cfg.indexed_mode    <= 1'b0;
      cfg.red_mask        <= 32'h00FF_0000;
      cfg.green_mask      <= 32'h0000_FF00;
      cfg.blue_mask       <= 32'h0000_00FF;
      cfg.red_shift       <= 5'd16;
      cfg.green_shift     <= 5'd8;
      cfg.blue_shift      <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        REG_INDEXED_MODE:    cfg.indexed_mode    <= cfg_data[0];
        REG_RED_MASK: begin
          cfg.red_mask  <= cfg_data;
          cfg.red_shift <= data_shift;
        end
        REG_GREEN_MASK: begin
          cfg.green_mask  <= cfg_data;
          cfg.green_shift <= data_shift;
        end
        REG_BLUE_MASK: begin
          cfg.blue_mask  <= cfg_data;
          cfg.blue_shift <= data_shift;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/sv/pxu_argb_checker.sv
module pxu_argb_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  output int          mismatches,
  output int          argb_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import pxu_pkg::*;

  logic [2:0]  fmt_bytes;
  logic        fmt_indexed;
  logic [31:0] fmt_red_mask;
  logic [31:0] fmt_green_mask;
  logic [31:0] fmt_blue_mask;
  logic [23:0] shadow_palette [PALETTE_ENTRIES];
  logic [31:0] argb_due [$];

  initial begin
    mismatches   = 0;
    argb_pending = 0;
  end

  function automatic logic [4:0] low_set_bit(input logic [31:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) n = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [7:0] mask_channel(input logic [31:0] pix, input logic [31:0] m);
    logic [31:0] v;
    v = (pix & m) >> low_set_bit(m);
    return v[7:0];
  endfunction

  function automatic logic [31:0] unpack_to_argb(input logic [31:0] word);
    logic [31:0] pix;
    logic [23:0] rgb;
    case (fmt_bytes)
      3'd0:    pix = 32'd0;
      3'd1:    pix = {24'd0, word[7:0]};
      3'd2:    pix = {16'd0, word[15:0]};
      3'd3:    pix = {8'd0, word[23:0]};
      default: pix = word;
    endcase
    if (fmt_indexed && pix < PALETTE_ENTRIES)
      rgb = shadow_palette[pix];
    else
      rgb = {mask_channel(pix, fmt_red_mask), mask_channel(pix, fmt_green_mask),
             mask_channel(pix, fmt_blue_mask)};
    return {8'hFF, rgb};
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      fmt_bytes      = 3'd4;
      fmt_indexed    = 1'b0;
      fmt_red_mask   = 32'h00FF0000;
      fmt_green_mask = 32'h0000FF00;
      fmt_blue_mask  = 32'h000000FF;
      for (int i = 0; i < PALETTE_ENTRIES; i++) shadow_palette[i] = 24'd0;
      argb_due.delete();
      argb_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BYTES_PER_PIXEL: fmt_bytes      = cfg_data[2:0];
          REG_INDEXED_MODE:    fmt_indexed    = cfg_data[0];
          REG_RED_MASK:        fmt_red_mask   = cfg_data;
          REG_GREEN_MASK:      fmt_green_mask = cfg_data;
          REG_BLUE_MASK:       fmt_blue_mask  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_PALETTE_WRITE) begin
          if (s_tdata[39:32] < PALETTE_ENTRIES)
            shadow_palette[s_tdata[39:32]] = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56]};
        end else begin
          argb_due.push_back(unpack_to_argb(s_tdata[31:0]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (argb_due.size() == 0) begin
          $error("argb_pixel: expected none, actual %08h", m_tdata);
          mismatches++;
        end else begin
          want = argb_due.pop_front();
          if (m_tdata !== want) begin
            $error("argb_pixel: expected %08h, actual %08h", want, m_tdata);
            mismatches++;
          end
        end
      end
      argb_pending = argb_due.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pxu_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_BYTES_PER_PIXEL;
  logic [31:0] cfg_data = 32'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = 64'd0;
  logic        s_tuser = CMD_CONVERT;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int mismatches;
  int argb_pending;

  // Idling control: calm turns off random gaps on both sides; each bump of
  // hold_off_asked makes the result side hold off for a long stretch.
  bit calm = 1'b0;
  int hold_off_asked = 0;
  int hold_off_done = 0;
  int hold_left = 0;

  // Shadow of the indexed setting, used only to shape pixel values
  bit cur_indexed = 1'b0;
  logic [2:0] cur_bytes = 3'd4;

  pixel_unpack_to_argb8888_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pxu_argb_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .argb_pending(argb_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: random stalls, long hold-off on request, steady when calm.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_off_asked != hold_off_done) begin
      hold_off_done++;
      hold_left = 80;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // Put one register write on the config channel; the caller drops valid.
  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program the whole source format; only called while the unit is idle.
  task automatic set_format(input logic [2:0] bytes, input bit indexed,
                            input logic [31:0] rmask, input logic [31:0] gmask,
                            input logic [31:0] bmask);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(REG_BYTES_PER_PIXEL, {noise[31:3], bytes});
    noise = $urandom;
    write_reg(REG_INDEXED_MODE, {noise[31:1], indexed});
    write_reg(REG_RED_MASK, rmask);
    write_reg(REG_GREEN_MASK, gmask);
    write_reg(REG_BLUE_MASK, bmask);
    cfg_valid <= 1'b0;
    cur_indexed = indexed;
    cur_bytes = bytes;
  endtask

  // Offer one request; optionally idle first. Returns at the accepting edge.
  task automatic send_request(input logic cmd, input logic [63:0] data);
    if (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic convert_pixel(input logic [31:0] word);
    logic [31:0] noise;
    noise = $urandom;
    send_request(CMD_CONVERT, {noise, word});
  endtask

  task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    send_request(CMD_PALETTE_WRITE, {b, g, r, idx, 32'($urandom)});
  endtask

  // Hold until every result has arrived, then cover the pipeline depth.
  // Wait for a clock edge first so the checker has counted the last request.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (argb_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] random_mask();
    int w;
    int pos;
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2, 3: begin
        w = $urandom_range(1, 10);
        pos = $urandom_range(0, 31);
        return ((32'd1 << w) - 32'd1) << pos;
      end
      4: return $urandom;
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Indexed mode mostly sees small pixels so that the palette gets read.
  function automatic logic [31:0] random_pixel();
    logic [31:0] word;
    word = $urandom;
    if (cur_indexed && cur_bytes != 3'd1 && $urandom_range(9) < 6) word[31:8] = 24'd0;
    return word;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset format: 4 bytes, truecolor with default RGB masks
    convert_pixel(32'h00000000);
    convert_pixel(32'hFFFFFFFF);
    convert_pixel(32'h12345678);
    write_entry(8'h00, 8'hFF, 8'h00, 8'hFF);
    write_entry(8'hFF, 8'h00, 8'hFF, 8'h00);
    write_entry(8'h5A, 8'hA5, 8'h3C, 8'hC3);
    write_entry(8'h80, 8'hFF, 8'hFF, 8'hFF);
    settle();

    // One-byte indexed; upper bytes must be dropped, an unwritten entry reads zero
    set_format(3'd1, 1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF);
    convert_pixel(32'hABCDEF00);
    convert_pixel(32'h000000FF);
    convert_pixel(32'h1234565A);
    convert_pixel(32'h00000011);
    settle();

    // Two-byte indexed: a pixel past the palette takes the masked path
    set_format(3'd2, 1'b1, 32'h0000F800, 32'h000007E0, 32'h0000001F);
    convert_pixel(32'h00000080);
    convert_pixel(32'hFFFF1234);
    settle();

    // Zero byte count gives pixel zero
    set_format(3'd0, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'h80000000);
    convert_pixel(32'hFFFFFFFF);
    settle();

    // Byte count above four acts as four; zero green mask reads zero
    set_format(3'd7, 1'b0, 32'hFFFFFFFF, 32'h00000000, 32'h80000000);
    convert_pixel(32'hFFFFFFFF);
    convert_pixel(32'h7FFFFFFF);
    settle();

    // Scattered masks
    set_format(3'd5, 1'b0, 32'h00F00F00, 32'h000000F0, 32'hFF000000);
    convert_pixel(32'hA5C35A3C);
    convert_pixel(32'hFFFFFFFF);
    settle();

    // Three bytes truecolor, then a palette write in truecolor mode
    set_format(3'd3, 1'b0, 32'h00FF0000, 32'h0000FF00, 32'h000000FF);
    convert_pixel(32'hAABBCCDD);
    write_entry(8'h01, 8'h12, 8'h34, 8'h56);
    settle();

    set_format(3'd1, 1'b1, 32'h00FF0000, 32'h0000FF00, 32'h000000FF);
    convert_pixel(32'h00000001);
    settle();

    // Random phases: fresh format each time, palette writes mixed in
    for (int ph = 0; ph < 8; ph++) begin
      set_format(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 random_mask(), random_mask(), random_mask());
      calm = (ph == 3);
      if (ph == 5) hold_off_asked++;
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(99) < 25)
          write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
          convert_pixel(random_pixel());
      end
      settle();
      calm = 1'b0;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("pixel_unpack_to_argb8888_unit regression: pass");
    else
      $display("pixel_unpack_to_argb8888_unit regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("pixel_unpack_to_argb8888_unit regression: fail");
    $finish;
  end

endmodule

FILE: pixel_unpack_to_argb8888_unit.f
hw/rtl/pxu_pkg.sv
hw/rtl/pxu_ram.sv
hw/rtl/pxu_cfg.sv
hw/rtl/pixel_unpack_to_argb8888_unit.sv
tb/sv/pxu_argb_checker.sv
tb/sv/tb_top.sv
